>>> hw/rtl/box_filter_mipmap_builder_core_macros.svh
// assertion helpers for the mipmap builder
`ifndef BOX_FILTER_MIPMAP_BUILDER_CORE_MACROS_SVH
`define BOX_FILTER_MIPMAP_BUILDER_CORE_MACROS_SVH
`ifndef SYNTH
`define BFMB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfmb assertion failed");
`define BFMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfmb assertion failed");
`else
`define BFMB_ASSERT_SAME(label, clk, rst, ante, cons)
`define BFMB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/bfmb_pkg.sv
package bfmb_pkg;

   localparam int MAX_SIDE_LOG2 = 10;
   localparam int LVL_W         = 4;
   localparam int COORD_W       = 10;
   localparam int SIDE_W        = MAX_SIDE_LOG2 + 1;
   localparam int PAIR_AW       = MAX_SIDE_LOG2;
   localparam int PAIR_DEPTH    = (1 << MAX_SIDE_LOG2) - 1;
   localparam logic [LVL_W-1:0] SIDE_LOG2_RESET = 4'd8;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb8_type;

   typedef struct packed {
      logic [8:0] blue;
      logic [8:0] green;
      logic [8:0] red;
   } rgb9_type;

   typedef struct packed {
      logic [9:0] blue;
      logic [9:0] green;
      logic [9:0] red;
   } rgb10_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_SUM
   } state_type;

endpackage

>>> hw/rtl/bfmb_add_unit.sv
module bfmb_add_unit
   import bfmb_pkg::*;
(
   input  rgb9_type  opa,
   input  rgb9_type  opb,
   output rgb10_type sum
);

   // three channel adders, shared by pair sums and block sums
   assign sum.red   = {1'b0, opa.red}   + {1'b0, opb.red};
   assign sum.green = {1'b0, opa.green} + {1'b0, opb.green};
   assign sum.blue  = {1'b0, opa.blue}  + {1'b0, opb.blue};

endmodule

>>> hw/rtl/box_filter_mipmap_builder_core.sv
// 2x2 box filter mipmap builder
// req_* carries level-0 texels of a square texture in raster order, one
// transaction per texel. rsp_* returns, for every input, the level-0 texel
// followed by each coarser texel that input completes, fine to coarse;
// rsp_tlast marks the final result of an input, rsp_tuser the single texel
// of the coarsest level. csr_* writes side_log2 (values above 10 act as 10)
// and restarts the image at texel (0,0).
// An input is taken in the idle state; its level-0 result is then loaded
// into the output register from the emit state, and each coarser level
// adds a registered pair-row memory read and a pass through the shared
// channel adder. No new input is taken until the last result of the
// previous input is loaded. The output register holds a result until
// rsp_tready; while it is held csr_tready stays low and the sequencer
// waits in the emit state, though an input can be taken while idle.
// Reset (synchronous, active high) sets side_log2 to 8 and the counters to
// zero; the held texels and pair rows need no clearing since raster order
// writes each before it is read.
`include "box_filter_mipmap_builder_core_macros.svh"
module box_filter_mipmap_builder_core
   import bfmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata,   // side_log2[3:0], zero[7:4]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // level[3:0], tex_x[13:4], tex_y[23:14],
                                    // out_red[31:24], out_green[39:32],
                                    // out_blue[47:40]
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // image_done
);

   state_type state_ff, state_in;

   logic [LVL_W-1:0]   side_log2_ff, side_log2_in;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   rgb8_type           c_ff, c_in;
   rgb9_type           pair_ff;
   rgb9_type           rd_ff;
   rgb8_type           held_ff [MAX_SIDE_LOG2];
   rgb9_type           pair_mem [PAIR_DEPTH + 1];

   logic               rsp_valid_ff;
   logic [LVL_W-1:0]   rsp_level_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   rgb8_type           rsp_c_ff;
   logic               rsp_last_ff, rsp_done_ff;

   logic [LVL_W-1:0]   eff_lg;
   logic [SIDE_W-1:0]  side_w, idx_w, col_inc, row_inc;
   logic [PAIR_AW-1:0] idx;
   logic               req_acc, csr_acc, emit_go, at_top, stop;
   logic               held_we, mem_we, mem_re;
   rgb8_type           held_rd;
   rgb9_type           opa, opb;
   rgb10_type          sum;

   assign eff_lg = (side_log2_ff > LVL_W'(MAX_SIDE_LOG2)) ? LVL_W'(MAX_SIDE_LOG2)
                                                           : side_log2_ff;
   assign side_w = SIDE_W'(1) << eff_lg;

   assign req_acc = req_tvalid && req_tready;
   assign csr_acc = csr_tvalid && csr_tready;
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign at_top  = lvl_ff >= eff_lg;
   assign stop    = at_top || !x_ff[0] || !y_ff[0];
   assign held_we = emit_go && !at_top && !x_ff[0];
   assign mem_we  = emit_go && !at_top && x_ff[0] && !y_ff[0];
   assign mem_re  = emit_go && !at_top && x_ff[0] && y_ff[0];

   // rows of all levels packed back to back in one memory
   assign idx_w = side_w - (side_w >> lvl_ff) + SIDE_W'(x_ff >> 1);
   assign idx   = (idx_w > SIDE_W'(PAIR_DEPTH)) ? PAIR_AW'(PAIR_DEPTH)
                                                : idx_w[PAIR_AW-1:0];

   assign held_rd = held_ff[lvl_ff];

   always_comb begin
      if (state_ff == ST_SUM) begin
         opa = rd_ff;
         opb = pair_ff;
      end else begin
         opa = '{red: {1'b0, held_rd.red}, green: {1'b0, held_rd.green},
                 blue: {1'b0, held_rd.blue}};
         opb = '{red: {1'b0, c_ff.red}, green: {1'b0, c_ff.green},
                 blue: {1'b0, c_ff.blue}};
      end
   end

   bfmb_add_unit u_add (
      .opa (opa),
      .opb (opb),
      .sum (sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_acc) state_in = ST_EMIT;
         ST_EMIT: if (emit_go) state_in = stop ? ST_IDLE : ST_SUM;
         ST_SUM:  state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs, nothing is taken while reset is held
   always_comb begin
      csr_tready = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_tready = !rsp_valid_ff && !reset;
            req_tready = !csr_tvalid && !reset;
         end
         default: begin
            csr_tready = 1'b0;
            req_tready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      side_log2_in = side_log2_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lvl_in       = lvl_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      c_in         = c_ff;
      col_inc      = SIDE_W'(col_ff) + SIDE_W'(1);
      row_inc      = SIDE_W'(row_ff) + SIDE_W'(1);
      if (csr_acc) begin
         side_log2_in = csr_tdata[LVL_W-1:0];
         col_in       = '0;
         row_in       = '0;
      end else if (req_acc) begin
         lvl_in = '0;
         x_in   = col_ff;
         y_in   = row_ff;
         c_in   = req_tdata;
         if (col_inc >= side_w) begin
            col_in = '0;
            row_in = (row_inc >= side_w) ? '0 : row_inc[COORD_W-1:0];
         end else begin
            col_in = col_inc[COORD_W-1:0];
         end
      end else if (state_ff == ST_SUM) begin
         c_in   = '{red: sum.red[9:2], green: sum.green[9:2], blue: sum.blue[9:2]};
         x_in   = x_ff >> 1;
         y_in   = y_ff >> 1;
         lvl_in = lvl_ff + LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_log2_ff <= SIDE_LOG2_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_log2_ff <= side_log2_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      c_ff   <= c_in;
      if (emit_go) begin
         rsp_level_ff <= lvl_ff;
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         rsp_c_ff     <= c_ff;
         rsp_last_ff  <= stop;
         rsp_done_ff  <= (lvl_ff == eff_lg);
      end
      if (held_we) begin
         held_ff[lvl_ff] <= c_ff;
      end
      if (mem_re) begin
         pair_ff <= '{red: sum.red[8:0], green: sum.green[8:0], blue: sum.blue[8:0]};
      end
   end

   // pair-row memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pair_mem[idx] <= '{red: sum.red[8:0], green: sum.green[8:0],
                            blue: sum.blue[8:0]};
      end
      if (mem_re) begin
         rd_ff <= pair_mem[idx];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_c_ff.blue, rsp_c_ff.green, rsp_c_ff.red,
                        rsp_y_ff, rsp_x_ff, rsp_level_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   `BFMB_ASSERT_NEXT(a_accept_emit, clock, reset, req_acc, state_ff == ST_EMIT)
   `BFMB_ASSERT_NEXT(a_read_then_sum, clock, reset, mem_re, state_ff == ST_SUM)
   `BFMB_ASSERT_SAME(a_level_bound, clock, reset, state_ff == ST_EMIT, lvl_ff <= eff_lg)
   `BFMB_ASSERT_SAME(a_done_top, clock, reset, rsp_valid_ff && rsp_done_ff,
                     rsp_level_ff == eff_lg && rsp_last_ff)

endmodule

>>> dv/tb_box_filter_mipmap_builder_core.sv
module tb_box_filter_mipmap_builder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bfmb_pkg::*;

   localparam int IDLE_PCT     = 34;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 430;

   typedef struct {
      logic [LVL_W-1:0]   level;
      logic [COORD_W-1:0] tex_x;
      logic [COORD_W-1:0] tex_y;
      rgb8_type           color;
      logic               last_of_run;
      logic               image_done;
   } mip_texel_type;

   class mip_scoreboard;
      logic [LVL_W-1:0] side_reg;
      int               col;
      int               row;
      rgb8_type         held_tex [0:MAX_SIDE_LOG2];
      rgb9_type         pair_row [0:PAIR_DEPTH];
      mip_texel_type    expected_texels[$];
      int               failures;
      int               checked;
      int               deepest;

      function new();
         side_reg = SIDE_LOG2_RESET;
         col      = 0;
         row      = 0;
         failures = 0;
         checked  = 0;
         deepest  = 0;
      endfunction

      function void set_side(logic [LVL_W-1:0] value);
         side_reg = value;
         col      = 0;
         row      = 0;
      endfunction

      function int pending();
         return expected_texels.size();
      endfunction

      // truncated mean of the four texels behind two pair sums, one channel
      function logic [7:0] quarter(logic [8:0] upper, logic [8:0] lower);
         logic [9:0] total;
         total = upper + lower;
         return total[9:2];
      endfunction

      // walk the cascade this level-0 texel triggers, fine to coarse
      function void note_texel(logic [23:0] data);
         int            lg;
         int            side;
         int            lvl;
         int            idx;
         int            x;
         int            y;
         rgb8_type      c;
         rgb9_type      pair;
         mip_texel_type t;
         lg   = (side_reg > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : int'(side_reg);
         side = 1 << lg;
         x    = col;
         y    = row;
         lvl  = 0;
         c    = data;
         forever begin
            t.level       = LVL_W'(lvl);
            t.tex_x       = COORD_W'(x);
            t.tex_y       = COORD_W'(y);
            t.color       = c;
            t.image_done  = (lvl == lg);
            t.last_of_run = (lvl >= lg) || ((x & 1) == 0) || ((y & 1) == 0);
            expected_texels = {expected_texels, t};
            if (lvl >= lg) break;
            if ((x & 1) == 0) begin
               held_tex[lvl] = c;
               break;
            end
            pair.red   = held_tex[lvl].red + c.red;
            pair.green = held_tex[lvl].green + c.green;
            pair.blue  = held_tex[lvl].blue + c.blue;
            idx = side - (side >> lvl) + (x >> 1);
            if (idx > PAIR_DEPTH) idx = PAIR_DEPTH;
            if ((y & 1) == 0) begin
               pair_row[idx] = pair;
               break;
            end
            c.red   = quarter(pair_row[idx].red, pair.red);
            c.green = quarter(pair_row[idx].green, pair.green);
            c.blue  = quarter(pair_row[idx].blue, pair.blue);
            x   = x >> 1;
            y   = y >> 1;
            lvl = lvl + 1;
         end
         if (lvl > deepest) deepest = lvl;
         col++;
         if (col >= side) begin
            col = 0;
            row++;
            if (row >= side) row = 0;
         end
      endfunction

      function void check_texel(logic [47:0] data, logic last, logic done);
         mip_texel_type got;
         mip_texel_type want;
         got.level       = data[3:0];
         got.tex_x       = data[13:4];
         got.tex_y       = data[23:14];
         got.color       = data[47:24];
         got.last_of_run = last;
         got.image_done  = done;
         checked++;
         if (expected_texels.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result with nothing pending: level %0d (%0d,%0d) rgb %h",
                        $realtime, got.level, got.tex_x, got.tex_y, got.color);
            return;
         end
         want = expected_texels.pop_front();
         if (got.level !== want.level || got.tex_x !== want.tex_x ||
             got.tex_y !== want.tex_y || got.color.red !== want.color.red ||
             got.color.green !== want.color.green || got.color.blue !== want.color.blue ||
             got.last_of_run !== want.last_of_run || got.image_done !== want.image_done)
         begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: mismatch, expected level %0d (%0d,%0d) rgb %h/%h/%h last %b done %b",
                        $realtime, want.level, want.tex_x, want.tex_y, want.color.red,
                        want.color.green, want.color.blue, want.last_of_run, want.image_done);
               $display("             got      level %0d (%0d,%0d) rgb %h/%h/%h last %b done %b",
                        got.level, got.tex_x, got.tex_y, got.color.red,
                        got.color.green, got.color.blue, got.last_of_run, got.image_done);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_tvalid;
   logic        csr_tready;
   logic [7:0]  csr_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   logic          calm;
   mip_scoreboard sb;
   logic [23:0]   texel_q[$];
   int            texels_sent;
   int            settings_written;
   int            quiet_cycles;

   box_filter_mipmap_builder_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // lean on the extremes so the channel sums hit their limits often
   function logic [7:0] pick_channel();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function logic [23:0] pick_texel();
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = pick_channel();
      g = pick_channel();
      b = pick_channel();
      return {b, g, r};
   endfunction

   task queue_random(int n);
      repeat (n) texel_q = {texel_q, pick_texel()};
   endtask

   task send_texels();
      while (texel_q.size() > 0) begin
         while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= texel_q.pop_front();
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
   endtask

   // only write the register once the block has drained
   task write_side(logic [3:0] value);
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {4'b0000, value};
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles     = 0;
         texels_sent      = 0;
         settings_written = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            sb.note_texel(req_tdata);
            texels_sent++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_texel(rsp_tdata, rsp_tlast, rsp_tuser);
         if (csr_tvalid && csr_tready) begin
            sb.set_side(csr_tdata[3:0]);
            settings_written++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_tvalid && csr_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, sb.pending());
            $display("tb_box_filter_mipmap_builder_core failed");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int lg;
      int n;
      int random_sent;
      sb               = new();
      reset            = 1'b1;
      csr_tvalid       = 1'b0;
      csr_tdata        = 8'h00;
      req_tvalid       = 1'b0;
      req_tdata        = 24'h000000;
      calm             = 1'b0;
      random_sent      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default side right after reset
      texel_q = '{24'h000000, 24'hFFFFFF, 24'h80FF01};
      send_texels();
      // side of one: each texel is a whole image
      write_side(4'd0);
      texel_q = '{24'h000000, 24'hFFFFFF, 24'h5AA55A};
      send_texels();
      // two back-to-back 2x2 images, all-ones then mixed extremes
      write_side(4'd1);
      texel_q = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF};
      send_texels();
      // partial image, then restart with an oversized side
      write_side(4'd2);
      queue_random(5);
      send_texels();
      write_side(4'd15);
      queue_random(3);
      send_texels();
      write_side(4'd1);
      queue_random(4);
      send_texels();

      while (random_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               lg = $urandom_range(10, 15);
               n  = $urandom_range(1, 40);
            end
            1: begin
               lg = $urandom_range(4, 9);
               n  = $urandom_range(1, 80);
            end
            2: begin
               lg = 4;
               n  = 256;
            end
            default: begin
               lg = $urandom_range(0, 3);
               n  = (1 << (2 * lg)) * $urandom_range(1, 2);
               if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
            end
         endcase
         if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
         calm = (random_sent >= 150 && random_sent < 260);
         write_side(4'(lg));
         queue_random(n);
         send_texels();
         random_sent += n;
      end
      calm = 1'b0;

      do @(posedge clock); while (sb.pending() != 0);
      repeat (20) @(posedge clock);
      $display("run: %0d texels in, %0d mipmap texels checked, %0d side settings written",
               texels_sent, sb.checked, settings_written);
      $display("deepest cascade reached level %0d, %0d mismatches", sb.deepest, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb_box_filter_mipmap_builder_core passed");
      else
         $display("tb_box_filter_mipmap_builder_core failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bfmb_pkg.sv
hw/rtl/bfmb_add_unit.sv
hw/rtl/box_filter_mipmap_builder_core.sv
dv/tb_box_filter_mipmap_builder_core.sv
